[hw/rtl/ovl_pkg.sv]
// Package for the ordered value list: sizes, command and status codes,
// and the structs passed between the top level and the cell chain.
// No dependencies.
package ovl_pkg;

  localparam int unsigned Depth    = 16;
  localparam int unsigned CountW   = $clog2(Depth + 1);
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned EntryCntW = 5;

  localparam logic [CmdW-1:0] CMD_APPEND = 2'd0;
  localparam logic [CmdW-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd2;

  localparam logic [StatusW-1:0] STATUS_OK      = 2'd0;
  localparam logic [StatusW-1:0] STATUS_MISSING = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL    = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ovl_state_e;

  // Broadcast to every cell.
  typedef struct packed {
    logic              capture;  // latch compare result against probe
    logic [ValueW-1:0] probe;
    logic              append;   // execute phase of an append
    logic              remove;   // execute phase of a remove
    logic [ValueW-1:0] value;
  } cell_ctrl_t;

  // Handed from a cell to its right neighbor.
  typedef struct packed {
    logic occ;
    logic hit;   // some cell at or left of here matched
  } cell_fwd_t;

  // Handed from a cell to its left neighbor.
  typedef struct packed {
    logic              occ;
    logic [ValueW-1:0] entry;
  } cell_bwd_t;

endpackage

[hw/rtl/ovl_cell.sv]
// One slot of the ordered value list: holds a value, its occupied flag
// and the latched compare result. Depends on ovl_pkg.
module ovl_cell
  import ovl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cell_fwd_t  left_i,
  input  cell_bwd_t  right_i,
  output cell_fwd_t  right_o,
  output cell_bwd_t  left_o
);

  logic              occ_q, occ_d;
  logic              match_q, match_d;
  logic [ValueW-1:0] entry_q, entry_d;
  logic              shift;

  assign shift = ctrl_i.remove && (left_i.hit || match_q);

  always_comb begin
    occ_d   = occ_q;
    entry_d = entry_q;
    match_d = match_q;
    if (ctrl_i.capture) begin
      match_d = occ_q && (entry_q == ctrl_i.probe);
    end
    if (ctrl_i.append && !occ_q && left_i.occ) begin
      // first free slot takes the new tail value
      occ_d   = 1'b1;
      entry_d = ctrl_i.value;
    end else if (shift) begin
      // pull the neighbor down to close the gap
      occ_d   = right_i.occ;
      entry_d = right_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      occ_q   <= occ_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign right_o.occ  = occ_q;
  assign right_o.hit  = left_i.hit || match_q;
  assign left_o.occ   = occ_q;
  assign left_o.entry = entry_q;

endmodule

[hw/rtl/ordered_value_list.sv]
// Top level of the ordered value list: command port, sequencer, count
// and the chain of ovl_cell slots. Depends on ovl_pkg and ovl_cell.
//
//   port group        direction  contents
//   start / busy      in / out   command transaction: command_i, value_i
//   done_o            out        result strobe: status_o, entry_count_o
//
// In the accept cycle every cell compares its value with value_i and
// latches the outcome; in the execute cycle (busy high) the first-match
// flag ripples along the chain, cells append or shift down one place,
// and the result is registered. done_o pulses the following cycle, when
// a new command may already be accepted. Reset clears the occupied flags
// and the count; stored values are not reset. The receiver cannot stall
// results, so none is ever held back.
module ordered_value_list
  import ovl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [CmdW-1:0]      command_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                 done_o,
  output logic [StatusW-1:0]   status_o,
  output logic [EntryCntW-1:0] entry_count_o
);

  ovl_state_e state_q, state_d;

  logic [CmdW-1:0]    cmd_q;
  logic [ValueW-1:0]  value_q;
  logic [CountW-1:0]  count_q, count_d;
  logic               done_q, done_d;
  logic [StatusW-1:0] status_q, status_d;
  logic               accept;
  logic               found;
  logic               full;

  cell_ctrl_t ctrl;
  cell_fwd_t  fwd [Depth+1];
  cell_bwd_t  bwd [Depth+1];

  assign accept = start && (state_q == ST_IDLE);

  // Broadcast control: compare on accept, act during execute.
  assign ctrl.capture = accept;
  assign ctrl.probe   = value_i;
  assign ctrl.append  = (state_q == ST_EXEC) && (cmd_q == CMD_APPEND);
  assign ctrl.remove  = (state_q == ST_EXEC) && (cmd_q == CMD_REMOVE);
  assign ctrl.value   = value_q;

  // Chain ends: slot zero sees an occupied left neighbor, the last slot
  // pulls in an empty one.
  assign fwd[0].occ   = 1'b1;
  assign fwd[0].hit   = 1'b0;
  assign bwd[Depth].occ   = 1'b0;
  assign bwd[Depth].entry = '0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    ovl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .left_i (fwd[i]),
      .right_i(bwd[i+1]),
      .right_o(fwd[i+1]),
      .left_o (bwd[i])
    );
  end

  assign found = fwd[Depth].hit;
  assign full  = fwd[Depth].occ;

  // Sequencer: decide status and new count in the execute cycle.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    done_d   = 1'b0;
    status_d = status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d  = ST_IDLE;
        done_d   = 1'b1;
        status_d = STATUS_OK;
        case (cmd_q)
          CMD_APPEND: begin
            if (full) begin
              status_d = STATUS_FULL;
            end else begin
              count_d = count_q + CountW'(1);
            end
          end
          CMD_SEARCH: begin
            if (!found) begin
              status_d = STATUS_MISSING;
            end
          end
          CMD_REMOVE: begin
            if (found) begin
              count_d = count_q - CountW'(1);
            end else begin
              status_d = STATUS_MISSING;
            end
          end
          default: begin
            // unused code: no operation, report done
            status_d = STATUS_OK;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Hold the command and result payloads; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      value_q <= value_i;
    end
    status_q <= status_d;
  end

  assign busy          = (state_q == ST_EXEC);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_count_o = EntryCntW'(count_q);

endmodule

[tb/tb_ordered_value_list.sv]
// Testbench for ordered_value_list: directed and random list commands
// checked against a queue-based prediction of the list contents.
// Depends on ovl_pkg and the ordered_value_list RTL.
module tb_ordered_value_list;
  import ovl_pkg::*;

  // Command code 3 is left unused by the block and must act as a no-op.
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [EntryCntW-1:0] entry_count;
  } list_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [CmdW-1:0]          command_i;
  logic signed [ValueW-1:0] value_i;
  logic                     done_o;
  logic [StatusW-1:0]       status_o;
  logic [EntryCntW-1:0]     entry_count_o;

  // Predicted list contents, oldest entry at index 0.
  logic [ValueW-1:0] held_values[$];
  // Results owed by the block, oldest first.
  list_result_t      owed_results[$];
  // Values reused often so that duplicates and hits are frequent.
  logic [ValueW-1:0] value_pool[8];
  int unsigned       mismatch_count;
  // When set, the sender issues commands back to back.
  bit                no_gaps;

  ordered_value_list u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Apply one command to the predicted list and return what the block owes.
  function automatic list_result_t apply_list_command(logic [CmdW-1:0] cmd,
                                                      logic [ValueW-1:0] val);
    list_result_t res;
    int           hit_pos;
    res.status = STATUS_OK;
    hit_pos    = -1;
    foreach (held_values[i]) begin
      if (hit_pos < 0 && held_values[i] == val) hit_pos = i;
    end
    case (cmd)
      CMD_APPEND: begin
        if (held_values.size() >= Depth) res.status = STATUS_FULL;
        else held_values.push_back(val);
      end
      CMD_SEARCH: begin
        if (hit_pos < 0) res.status = STATUS_MISSING;
      end
      CMD_REMOVE: begin
        // Only the oldest match goes; later entries close the gap.
        if (hit_pos < 0) res.status = STATUS_MISSING;
        else held_values.delete(hit_pos);
      end
      default: ;
    endcase
    res.entry_count = EntryCntW'(held_values.size());
    return res;
  endfunction

  // Monitor: predict on every accepted transaction, check every strobe.
  // All signals here are the values from before the edge.
  always @(posedge clk_i) begin
    list_result_t exp_res;
    if (rst_ni) begin
      if (done_o) begin
        if (owed_results.size() == 0) begin
          $error("result with nothing expected: status=%0d entry_count=%0d",
                 status_o, entry_count_o);
          mismatch_count++;
        end else begin
          exp_res = owed_results.pop_front();
          if (status_o !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, status_o);
            mismatch_count++;
          end
          if (entry_count_o !== exp_res.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   exp_res.entry_count, entry_count_o);
            mismatch_count++;
          end
        end
      end
      // Check the strobe first: a result never lands on its own accept edge.
      if (start && !busy) owed_results.push_back(apply_list_command(command_i, value_i));
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one command from a falling edge, hold it until the block takes it,
  // then idle for a gap chosen by pick_gap. Returns on a falling edge.
  task automatic issue_command(logic [CmdW-1:0] cmd, logic [ValueW-1:0] val);
    int unsigned gap;
    start     <= 1'b1;
    command_i <= cmd;
    value_i   <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Search and remove on an empty list, and the unused code on it.
  task automatic test_empty_list();
    issue_command(CMD_SEARCH, 32'h0000_0000);
    issue_command(CMD_REMOVE, 32'h8000_0000);
    issue_command(CMD_UNUSED, 32'hFFFF_FFFF);
  endtask

  // Fill to the top with extreme and duplicate values, then overflow once.
  task automatic test_fill_and_overflow();
    logic [ValueW-1:0] fill_vals[16];
    fill_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001,
                  32'h1234_5678, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0001,
                  32'hDEAD_BEEF, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_002A};
    foreach (fill_vals[i]) issue_command(CMD_APPEND, fill_vals[i]);
    issue_command(CMD_APPEND, 32'h0BAD_CAFE);
  endtask

  // Duplicates: search finds one, remove takes the oldest only.
  task automatic test_duplicates_and_misses();
    issue_command(CMD_SEARCH, 32'h0000_0001);
    issue_command(CMD_REMOVE, 32'h0000_0001);
    issue_command(CMD_SEARCH, 32'h0000_0001);
    issue_command(CMD_REMOVE, 32'h0BAD_CAFE);
    issue_command(CMD_UNUSED, 32'h7FFF_FFFF);
  endtask

  // Random traffic in phases that lean toward filling or draining the list,
  // so that both the full and the empty corner are visited repeatedly.
  task automatic test_random_traffic(int unsigned phases, int unsigned per_phase);
    int unsigned       append_pct;
    int unsigned       r;
    logic [CmdW-1:0]   cmd;
    logic [ValueW-1:0] val;
    foreach (value_pool[i]) value_pool[i] = (i < 2) ? {i[0], {(ValueW-1){~i[0]}}}
                                                    : $urandom();
    for (int p = 0; p < phases; p++) begin
      case (p % 3)
        0:       append_pct = 75;
        1:       append_pct = 25;
        default: append_pct = 50;
      endcase
      no_gaps = (p % 4 == 3);
      for (int n = 0; n < per_phase; n++) begin
        r = $urandom_range(0, 99);
        if (r < 2) cmd = CMD_UNUSED;
        else if (r < append_pct) cmd = CMD_APPEND;
        else cmd = r[0] ? CMD_SEARCH : CMD_REMOVE;
        r = $urandom_range(0, 9);
        if (r < 4 && held_values.size() > 0)
          val = held_values[$urandom_range(0, held_values.size() - 1)];
        else if (r < 7) val = value_pool[$urandom_range(0, 7)];
        else val = $urandom();
        issue_command(cmd, val);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    mismatch_count = 0;
    no_gaps        = 1'b0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    command_i      = CMD_APPEND;
    value_i        = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_fill_and_overflow();
    test_duplicates_and_misses();
    test_random_traffic(17, 100);

    // Drop start, drain the owed results, then allow a few more cycles
    // so a stray strobe would still be caught.
    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) $display("[ordered_value_list] OK");
    else $display("[ordered_value_list] ERROR");
    $finish;
  end

  // Hold the run to a generous bound in case the handshake hangs.
  initial begin
    #4_000_000;
    $display("[ordered_value_list] ERROR");
    $finish;
  end

endmodule
